/* hdl/tmb_pkg.sv */
// Shared types and widths for the one-minute OHLC bar aggregator.
// No dependencies; every other file refers to this package by scoped names.
package tmb_pkg;

	localparam int unsigned MINUTE_W = 32;
	localparam int unsigned SECOND_W = 6;
	localparam int unsigned PRICE_W  = 32;
	localparam int unsigned TVOL_W   = 32;
	localparam int unsigned VOLUME_W = 48;

	typedef struct packed {
		logic [MINUTE_W-1:0] minute_index;
		logic [SECOND_W-1:0] second_in_minute;
		logic [PRICE_W-1:0]  last_price;
		logic [PRICE_W-1:0]  tick_high;
		logic [PRICE_W-1:0]  tick_low;
		logic [TVOL_W-1:0]   tick_volume;
		logic [PRICE_W-1:0]  open_interest;
	} tick_t;

	typedef struct packed {
		logic [MINUTE_W-1:0] out_minute;
		logic [PRICE_W-1:0]  out_open;
		logic [PRICE_W-1:0]  out_high;
		logic [PRICE_W-1:0]  out_low;
		logic [PRICE_W-1:0]  out_close;
		logic [VOLUME_W-1:0] out_volume;
		logic [PRICE_W-1:0]  out_interest;
	} bar_t;

endpackage

/* hdl/tmb_bar_core.sv */
// Open-bar state and the per-tick update: filtering, bar roll-over, OHLC widening
// and saturating volume. Uses tmb_pkg for the word types.
module tmb_bar_core #(
	parameter int PRICE_BITS  = 32,
	parameter int VOLUME_BITS = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tmb_pkg::tick_t tick,
	input  logic           fire,
	output logic           emit,
	output tmb_pkg::bar_t  bar
);

	localparam logic [tmb_pkg::PRICE_W-1:0] PRICE_MASK = (PRICE_BITS >= 32) ?
		{tmb_pkg::PRICE_W{1'b1}} :
		tmb_pkg::PRICE_W'((64'd1 << PRICE_BITS) - 64'd1);
	localparam int SUM_W = ((VOLUME_BITS > 32) ? VOLUME_BITS : 32) + 1;
	localparam logic [VOLUME_BITS-1:0] VOL_MAX = '1;

	logic                            have_bar_q;
	logic [tmb_pkg::MINUTE_W-1:0]    minute_q;
	logic [tmb_pkg::SECOND_W-1:0]    second_q;
	logic [tmb_pkg::PRICE_W-1:0]     open_q, high_q, low_q, close_q, interest_q;
	logic [VOLUME_BITS-1:0]          vol_q;

	logic [tmb_pkg::PRICE_W-1:0]     last_m, thigh_m, tlow_m, oi_m;
	logic                            older, keep, new_bar;
	logic [VOLUME_BITS-1:0]          vol_base, vol_next;
	logic [SUM_W-1:0]                vol_sum;
	logic [63:0]                     vol_wide;

	assign last_m  = tick.last_price & PRICE_MASK;
	assign thigh_m = tick.tick_high & PRICE_MASK;
	assign tlow_m  = tick.tick_low & PRICE_MASK;
	assign oi_m    = tick.open_interest & PRICE_MASK;

	// A tick earlier than the last accepted one is dropped; equal time is kept.
	assign older = (tick.minute_index < minute_q) ||
		((tick.minute_index == minute_q) && (tick.second_in_minute < second_q));
	assign keep    = (last_m != '0) && !(have_bar_q && older);
	assign new_bar = !have_bar_q || (tick.minute_index != minute_q);
	assign emit    = keep && have_bar_q && (tick.minute_index != minute_q);

	// Volume restarts at zero on a new bar; the very first tick adds nothing.
	assign vol_base = new_bar ? '0 : vol_q;
	assign vol_sum  = SUM_W'(vol_base) + SUM_W'(tick.tick_volume);
	always_comb begin
		if (!have_bar_q) begin
			vol_next = '0;
		end else if (vol_sum > SUM_W'(VOL_MAX)) begin
			vol_next = VOL_MAX;
		end else begin
			vol_next = vol_sum[VOLUME_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_bar_q <= 1'b0;
		end else if (fire && keep) begin
			have_bar_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && keep) begin
			second_q   <= tick.second_in_minute;
			close_q    <= last_m;
			interest_q <= oi_m;
			vol_q      <= vol_next;
			if (new_bar) begin
				minute_q <= tick.minute_index;
				open_q   <= last_m;
				high_q   <= last_m;
				low_q    <= last_m;
			end else begin
				if (thigh_m > high_q) begin
					high_q <= thigh_m;
				end
				if (tlow_m < low_q) begin
					low_q <= tlow_m;
				end
			end
		end
	end

	assign vol_wide = 64'(vol_q);

	always_comb begin
		bar.out_minute   = minute_q;
		bar.out_open     = open_q;
		bar.out_high     = high_q;
		bar.out_low      = low_q;
		bar.out_close    = close_q;
		bar.out_volume   = vol_wide[tmb_pkg::VOLUME_W-1:0];
		bar.out_interest = interest_q;
	end

endmodule

/* hdl/tmb_out_reg.sv */
// Output register for finished bars with valid/stall handshake.
// Uses tmb_pkg for the bar word type.
module tmb_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  tmb_pkg::bar_t din,
	output logic          free,
	input  logic          stall,
	output logic          valid,
	output tmb_pkg::bar_t dout
);

	logic          valid_q;
	tmb_pkg::bar_t data_q;

	// The slot can take a word when empty or when its word leaves this cycle.
	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign dout  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= din;
		end
	end

endmodule

/* hdl/tick_to_minute_bar_aggregator.sv */
// The tick that closes a bar is held in the input register; the bar core then loads
// the finished bar into the output register, which raises bar_valid.
// Throughput: one tick per cycle while the bar side is not stalled; an input
// register and an output register sit on either side of the bar update logic.
// Reset (arst_n low) empties both registers and closes the open bar.
// Builds on tmb_pkg, tmb_bar_core and tmb_out_reg.
module tick_to_minute_bar_aggregator #(
	parameter int PRICE_BITS  = 32,
	parameter int VOLUME_BITS = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tick_valid,
	output logic           tick_stall,
	input  tmb_pkg::tick_t tick,
	output logic           bar_valid,
	input  logic           bar_stall,
	output tmb_pkg::bar_t  bar
);

	logic           valid_s1;
	tmb_pkg::tick_t tick_s1;
	logic           emit, out_free, advance;
	tmb_pkg::bar_t  bar_word;

	// The registered tick moves on unless it closes a bar and the output is full.
	assign advance    = valid_s1 && (!emit || out_free);
	assign tick_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick;
		end
	end

	tmb_bar_core #(
		.PRICE_BITS  (PRICE_BITS),
		.VOLUME_BITS (VOLUME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_s1),
		.fire   (advance),
		.emit   (emit),
		.bar    (bar_word)
	);

	tmb_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && emit),
		.din    (bar_word),
		.free   (out_free),
		.stall  (bar_stall),
		.valid  (bar_valid),
		.dout   (bar)
	);

endmodule

/* hdl/tmb_checker.sv */
// Port-level checks for the bar aggregator, attached by the bind at the end.
// Uses tmb_pkg for the bar word type.
module tmb_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          bar_valid,
	input logic          bar_stall,
	input tmb_pkg::bar_t bar
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && bar_stall |=> bar_valid)
		else $error("bar word dropped while stalled");

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && bar_stall |=> $stable(bar))
		else $error("bar word changed while stalled");

	// High only grows and low only shrinks from the opening price.
	a_high_low: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid |-> bar.out_high >= bar.out_low)
		else $error("bar high below bar low");

	a_open_range: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid |-> (bar.out_open <= bar.out_high) && (bar.out_open >= bar.out_low))
		else $error("bar open outside its high and low");

endmodule

bind tick_to_minute_bar_aggregator tmb_checker u_tmb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.bar_valid (bar_valid),
	.bar_stall (bar_stall),
	.bar       (bar)
);

/* tb/tb_tick_to_minute_bar_aggregator.sv */
// Self-checking testbench for tick_to_minute_bar_aggregator.
// Folds every accepted tick into its own copy of the open bar and checks each bar word.
// Depends on tmb_pkg and the aggregator RTL.
module tb_tick_to_minute_bar_aggregator;

	localparam int STALL_LIMIT = 2000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           tick_valid = 1'b0;
	logic           tick_stall;
	tmb_pkg::tick_t tick = '0;
	logic           bar_valid;
	logic           bar_stall = 1'b0;
	tmb_pkg::bar_t  bar;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len = 0;
	int errors = 0;
	int quiet_cycles = 0;

	// Open bar as this bench expects it.
	bit                           have_bar = 1'b0;
	logic [tmb_pkg::MINUTE_W-1:0] cur_minute = '0;
	logic [tmb_pkg::SECOND_W-1:0] cur_second = '0;
	logic [tmb_pkg::PRICE_W-1:0]  cur_open = '0;
	logic [tmb_pkg::PRICE_W-1:0]  cur_high = '0;
	logic [tmb_pkg::PRICE_W-1:0]  cur_low = '0;
	logic [tmb_pkg::PRICE_W-1:0]  cur_close = '0;
	logic [tmb_pkg::VOLUME_W-1:0] cur_volume = '0;
	logic [tmb_pkg::PRICE_W-1:0]  cur_interest = '0;
	tmb_pkg::bar_t                pending_bars[$];

	tick_to_minute_bar_aggregator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.bar_valid  (bar_valid),
		.bar_stall  (bar_stall),
		.bar        (bar)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Returns whether the tick changes the bar; a finished bar is queued for checking.
	function automatic bit fold_tick(input tmb_pkg::tick_t t);
		logic [tmb_pkg::VOLUME_W:0] vol_sum;
		tmb_pkg::bar_t done;
		if (t.last_price == '0)
			return 1'b0;
		if (have_bar && (t.minute_index < cur_minute ||
			(t.minute_index == cur_minute && t.second_in_minute < cur_second)))
			return 1'b0;
		if (!have_bar || t.minute_index != cur_minute) begin
			if (have_bar) begin
				done.out_minute   = cur_minute;
				done.out_open     = cur_open;
				done.out_high     = cur_high;
				done.out_low      = cur_low;
				done.out_close    = cur_close;
				done.out_volume   = cur_volume;
				done.out_interest = cur_interest;
				pending_bars.push_back(done);
			end
			cur_minute = t.minute_index;
			cur_open   = t.last_price;
			cur_high   = t.last_price;
			cur_low    = t.last_price;
			cur_close  = t.last_price;
			cur_volume = '0;
		end else begin
			if (t.tick_high > cur_high)
				cur_high = t.tick_high;
			if (t.tick_low < cur_low)
				cur_low = t.tick_low;
			cur_close = t.last_price;
		end
		cur_interest = t.open_interest;
		// The very first tick opens the bar without adding its volume.
		if (have_bar) begin
			vol_sum = {1'b0, cur_volume} + (tmb_pkg::VOLUME_W + 1)'(t.tick_volume);
			cur_volume = vol_sum[tmb_pkg::VOLUME_W] ? '1 : vol_sum[tmb_pkg::VOLUME_W-1:0];
		end
		have_bar = 1'b1;
		cur_second = t.second_in_minute;
		return 1'b1;
	endfunction

	function automatic tmb_pkg::tick_t make_tick(input logic [31:0] minute,
		input int second, input logic [31:0] last, input logic [31:0] hi,
		input logic [31:0] lo, input logic [31:0] vol, input logic [31:0] oi);
		tmb_pkg::tick_t t;
		t.minute_index     = minute;
		t.second_in_minute = second[tmb_pkg::SECOND_W-1:0];
		t.last_price       = last;
		t.tick_high        = hi;
		t.tick_low         = lo;
		t.tick_volume      = vol;
		t.open_interest    = oi;
		return t;
	endfunction

	// Mostly well-ordered ticks built on the current bar, with some noise mixed in.
	function automatic tmb_pkg::tick_t random_tick();
		tmb_pkg::tick_t t;
		int kind;
		int sec;
		kind = $urandom_range(99);
		t.minute_index = cur_minute;
		sec = cur_second + $urandom_range(0, 2);
		t.second_in_minute = (sec > 63) ? 6'd63 : sec[tmb_pkg::SECOND_W-1:0];
		if ($urandom_range(3) == 0) begin
			t.last_price = $urandom;
			t.tick_high  = $urandom;
			t.tick_low   = $urandom;
		end else begin
			t.last_price = 100000 + $urandom_range(0, 5000);
			t.tick_high  = t.last_price + $urandom_range(0, 300);
			t.tick_low   = t.last_price - $urandom_range(0, 300);
		end
		t.tick_volume   = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 1000);
		t.open_interest = $urandom;
		if (kind < 5) begin
			t.last_price = '0;
		end else if (kind < 10) begin
			if (cur_second != 0) begin
				sec = $urandom_range(0, cur_second - 1);
				t.second_in_minute = sec[tmb_pkg::SECOND_W-1:0];
			end else if (cur_minute != 0) begin
				t.minute_index = cur_minute - 1;
			end
		end else if (kind < 25 || !have_bar) begin
			t.minute_index = cur_minute +
				(($urandom_range(19) == 0) ? $urandom_range(2, 1 << 20) : 1);
			sec = $urandom_range(0, 59);
			t.second_in_minute = sec[tmb_pkg::SECOND_W-1:0];
		end
		return t;
	endfunction

	task automatic send_tick(input tmb_pkg::tick_t t, output bit kept);
		while ($urandom_range(99) < send_idle_pct) begin
			tick_valid <= 1'b0;
			@(negedge clk);
		end
		tick_valid <= 1'b1;
		tick <= t;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		kept = fold_tick(t);
		@(negedge clk);
	endtask

	task automatic drain_bars();
		tick_valid <= 1'b0;
		while (pending_bars.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic test_directed();
		tmb_pkg::tick_t ticks[$];
		bit kept;
		send_idle_pct = 27;
		recv_idle_pct = 60;
		ticks.push_back(make_tick(5, 10, 0, 300, 200, 50, 1));
		ticks.push_back(make_tick(5, 10, 1000, '1, 0, '1, 7));
		ticks.push_back(make_tick(5, 10, 2000, 3000, 500, 100, 8));
		ticks.push_back(make_tick(5, 9, 2500, '1, 0, 10, 9));
		ticks.push_back(make_tick(4, 59, 2500, '1, 0, 10, 9));
		ticks.push_back(make_tick(5, 63, 1500, '1, 0, '1, 9));
		ticks.push_back(make_tick(5, 60, 1700, 1800, 1600, 3, 10));
		ticks.push_back(make_tick(5, 63, 0, 1800, 1600, 3, 10));
		ticks.push_back(make_tick(6, 0, '1, '1, '1, 5, '1));
		ticks.push_back(make_tick(6, 0, 1, 0, 0, 0, 0));
		ticks.push_back(make_tick(7, 30, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5554,
			32'hAAAA_AAAA, 32'h5555_5555));
		ticks.push_back(make_tick(7, 31, 32'hAAAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA));
		ticks.push_back(make_tick(8, 0, 42, 43, 41, 1, 2));
		foreach (ticks[i])
			send_tick(ticks[i], kept);
		drain_bars();
	endtask

	// Full-volume ticks in one minute build a sum well past the tick volume width.
	task automatic test_large_volume();
		logic [31:0] minute;
		bit kept;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		minute = cur_minute + 1;
		repeat (30)
			send_tick(make_tick(minute, 20, 77, 80, 70, '1, 3), kept);
		send_tick(make_tick(minute + 1, 0, 90, 91, 89, 4, 5), kept);
		drain_bars();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
		input int n_ticks);
		int count;
		bit kept;
		count = 0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (count < n_ticks) begin
			send_tick(random_tick(), kept);
			if (kept)
				count++;
		end
		drain_bars();
	endtask

	// The bar side holds off while every tick closes a bar, so the block backs up.
	task automatic test_backpressure();
		bit kept;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_len = 200;
		@(negedge clk);
		repeat (16)
			send_tick(make_tick(cur_minute + 1, $urandom_range(0, 59),
				$urandom_range(1, 1 << 30), $urandom, $urandom, $urandom, $urandom), kept);
		drain_bars();
	endtask

	// Runs last: once the minute reaches its top, no later minute can be accepted.
	task automatic test_minute_extremes();
		bit kept;
		send_idle_pct = 27;
		recv_idle_pct = 60;
		send_tick(make_tick(32'h7FFF_FFFF, 5, 11, 12, 10, 1, 1), kept);
		send_tick(make_tick(32'h8000_0000, 5, 21, 22, 20, 2, 2), kept);
		send_tick(make_tick(32'hFFFF_FFFE, 59, 31, 32, 30, 3, 3), kept);
		send_tick(make_tick(32'hFFFF_FFFF, 0, 41, 42, 40, 4, 4), kept);
		send_tick(make_tick(32'hFFFF_FFFF, 63, 51, 52, 50, 5, 5), kept);
		send_tick(make_tick(32'h0000_0000, 63, 61, 62, 60, 6, 6), kept);
		drain_bars();
	endtask

	always @(negedge clk) begin
		if (hold_len > 0) begin
			bar_stall <= 1'b1;
			hold_len--;
		end else begin
			bar_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic check_field(input string fld, input logic [47:0] want,
		input logic [47:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, fld, want, got);
		end
	endtask

	always @(posedge clk) begin
		tmb_pkg::bar_t want;
		if (bar_valid && !bar_stall) begin
			if (pending_bars.size() == 0) begin
				errors++;
				$display("%0t: unexpected bar word, expected none, got %h", $time, bar);
			end else begin
				want = pending_bars.pop_front();
				check_field("out_minute", 48'(want.out_minute), 48'(bar.out_minute));
				check_field("out_open", 48'(want.out_open), 48'(bar.out_open));
				check_field("out_high", 48'(want.out_high), 48'(bar.out_high));
				check_field("out_low", 48'(want.out_low), 48'(bar.out_low));
				check_field("out_close", 48'(want.out_close), 48'(bar.out_close));
				check_field("out_volume", want.out_volume, bar.out_volume);
				check_field("out_interest", 48'(want.out_interest),
					48'(bar.out_interest));
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (bar_valid && !bar_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_tick_to_minute_bar_aggregator: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_large_volume();
		test_random_traffic(27, 60, 180);
		test_random_traffic(60, 27, 180);
		test_random_traffic(0, 0, 180);
		test_backpressure();
		test_minute_extremes();
		if (errors == 0) begin
			$display("tb_tick_to_minute_bar_aggregator: PASS");
		end else begin
			$display("tb_tick_to_minute_bar_aggregator: FAIL");
		end
		$finish;
	end

endmodule
